// File: hw/rtl/truncated_exp_series_assert.svh
// ---------------------------------------------------------------------------
// truncated_exp_series_assert.svh
// Assertion macros for the checker file of the series block (tes_props).
// ---------------------------------------------------------------------------
`ifndef TRUNCATED_EXP_SERIES_ASSERT_SVH
`define TRUNCATED_EXP_SERIES_ASSERT_SVH

// Clocked assertion, muted while reset is held
`define TES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset
`define TES_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tes_pkg.sv
// ---------------------------------------------------------------------------
// tes_pkg
// Widths and constants of the truncated exponential series block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

  // Series limits
  localparam int MAX_TERMS  = 12;
  localparam int FRAC_BITS  = 24;

  // Field widths
  localparam int BASE_W     = 7;
  localparam int COUNT_W    = 4;
  localparam int SUM_W      = 57;

  // Base clamp and magnitude
  localparam int BASE_LIMIT = 32;
  localparam int MAG_W      = 6;

  // |x|^k for k up to MAX_TERMS, and 12! (479001600)
  localparam int PW_W       = MAX_TERMS * (MAG_W - 1) + 1;
  localparam int FAC_W      = 29;

  // Divider: dividend is |x|^k with FRAC_BITS zeros below
  localparam int DIV_W      = PW_W + FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIV_W);

  // Multiply step counter
  localparam int MCNT_W     = $clog2(MAG_W);

endpackage

`default_nettype wire

// File: hw/rtl/tes_divider.sv
// ---------------------------------------------------------------------------
// tes_divider
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tes_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tes_pkg::DIV_W-1:0]   dividend,
  input  logic [tes_pkg::FAC_W-1:0]   divisor,
  output logic                        busy,
  output logic [tes_pkg::DIV_W-1:0]   quotient
);

  logic [tes_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [tes_pkg::FAC_W-1:0]  rem_r, rem_nxt;
  logic [tes_pkg::FAC_W-1:0]  dvs_r, dvs_nxt;
  logic [tes_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [tes_pkg::FAC_W+1:0]  trial;
  logic                       borrow;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial  = {1'b0, rem_r, quo_r[tes_pkg::DIV_W-1]} - {2'b00, dvs_r};
  assign borrow = trial[tes_pkg::FAC_W+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = tes_pkg::DCNT_W'(tes_pkg::DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      if (borrow) begin
        rem_nxt = {rem_r[tes_pkg::FAC_W-2:0], quo_r[tes_pkg::DIV_W-1]};
      end else begin
        rem_nxt = trial[tes_pkg::FAC_W-1:0];
      end
      quo_nxt = {quo_r[tes_pkg::DIV_W-2:0], ~borrow};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/truncated_exp_series.sv
// ---------------------------------------------------------------------------
// truncated_exp_series
// Partial sum 1 + x + ... + x^n/n! in signed Q32.24, each term truncated; n = 0 gives zero.
// ---------------------------------------------------------------------------
// Channel   Dir   Ports                                  Handshake
// input     in    in_base_value, in_term_count           in_valid / in_stall
// result    out   out_series_sum                         out_valid / out_stall
//
// Counts 0 and 1 skip the term loop: the request goes straight to the finish state.
// Each further term takes 6 shift-add steps for |x|^k and k!, 85 steps of the
// bit-serial divider and one accumulate; one request is in work at a time.
// Reset clears the control state only; no clearing pass is needed.
// A held result sits in the output register while the next request is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module truncated_exp_series (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tes_pkg::BASE_W-1:0]   in_base_value,
  input  logic        [tes_pkg::COUNT_W-1:0]  in_term_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tes_pkg::SUM_W-1:0]    out_series_sum
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic signed [tes_pkg::BASE_W-1:0] BASE_HI =
    tes_pkg::BASE_W'(tes_pkg::BASE_LIMIT);
  localparam logic signed [tes_pkg::BASE_W-1:0] BASE_LO =
    tes_pkg::BASE_W'(-tes_pkg::BASE_LIMIT);
  localparam logic [tes_pkg::COUNT_W-1:0] COUNT_MAX =
    tes_pkg::COUNT_W'(tes_pkg::MAX_TERMS);

  logic [1:0]                   state_r, state_nxt;
  logic [tes_pkg::MAG_W-1:0]    mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic [tes_pkg::COUNT_W-1:0]  n_r, n_nxt;
  logic [tes_pkg::COUNT_W-1:0]  k_r, k_nxt;
  logic [tes_pkg::PW_W-1:0]     pw_r, pw_nxt;
  logic [tes_pkg::FAC_W-1:0]    fac_r, fac_nxt;
  logic [tes_pkg::PW_W-1:0]     prod_r, prod_nxt;
  logic [tes_pkg::FAC_W-1:0]    facp_r, facp_nxt;
  logic [tes_pkg::MCNT_W-1:0]   mcnt_r, mcnt_nxt;
  logic [tes_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tes_pkg::SUM_W-1:0]    out_sum_r, out_sum_nxt;

  logic signed [tes_pkg::BASE_W-1:0] x_sat;
  logic        [tes_pkg::BASE_W-1:0] x_abs;
  logic        [tes_pkg::COUNT_W-1:0] n_sat;
  logic signed [tes_pkg::BASE_W:0]   x_p1;
  logic        [tes_pkg::SUM_W-1:0]  sum_init;
  logic        [tes_pkg::MAG_W-1:0]  k_ext;
  logic        [tes_pkg::PW_W-1:0]   prod_step;
  logic        [tes_pkg::FAC_W-1:0]  facp_step;
  logic        [tes_pkg::SUM_W-1:0]  term;
  logic                              div_start;
  logic                              div_busy;
  logic        [tes_pkg::DIV_W-1:0]  div_quo;

  // Clamp the request fields
  always_comb begin
    if (in_base_value > BASE_HI) begin
      x_sat = BASE_HI;
    end else if (in_base_value < BASE_LO) begin
      x_sat = BASE_LO;
    end else begin
      x_sat = in_base_value;
    end
    n_sat = (in_term_count > COUNT_MAX) ? COUNT_MAX : in_term_count;
  end

  assign x_abs    = x_sat[tes_pkg::BASE_W-1] ? -x_sat : x_sat;
  assign x_p1     = {x_sat[tes_pkg::BASE_W-1], x_sat} + 1'sb1;
  assign sum_init = {{(tes_pkg::SUM_W-tes_pkg::BASE_W-1){x_p1[tes_pkg::BASE_W]}}, x_p1}
                    << tes_pkg::FRAC_BITS;

  // Shift-add step, MSB first: |x|^k = |x|^(k-1) * |x| and k! = (k-1)! * k
  assign k_ext     = {{(tes_pkg::MAG_W-tes_pkg::COUNT_W){1'b0}}, k_r};
  assign prod_step = {prod_r[tes_pkg::PW_W-2:0], 1'b0} + (mag_r[mcnt_r] ? pw_r : '0);
  assign facp_step = {facp_r[tes_pkg::FAC_W-2:0], 1'b0} + (k_ext[mcnt_r] ? fac_r : '0);

  assign div_start = (state_r == ST_MUL) && (mcnt_r == '0);
  assign term      = div_quo[tes_pkg::SUM_W-1:0];

  tes_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({prod_step, {tes_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (facp_step),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    pw_nxt        = pw_r;
    fac_nxt       = fac_r;
    prod_nxt      = prod_r;
    facp_nxt      = facp_r;
    mcnt_nxt      = mcnt_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt  = x_abs[tes_pkg::MAG_W-1:0];
          neg_nxt  = x_sat[tes_pkg::BASE_W-1];
          n_nxt    = n_sat;
          k_nxt    = tes_pkg::COUNT_W'(2);
          pw_nxt   = tes_pkg::PW_W'(x_abs);
          fac_nxt  = tes_pkg::FAC_W'(1);
          prod_nxt = '0;
          facp_nxt = '0;
          mcnt_nxt = tes_pkg::MCNT_W'(tes_pkg::MAG_W - 1);
          sum_nxt  = (n_sat == '0) ? '0 : sum_init;
          state_nxt = (n_sat > tes_pkg::COUNT_W'(1)) ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        prod_nxt = prod_step;
        facp_nxt = facp_step;
        if (mcnt_r == '0) begin
          pw_nxt    = prod_step;
          fac_nxt   = facp_step;
          state_nxt = ST_DIV;
        end else begin
          mcnt_nxt = mcnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          // odd powers of a negative base subtract
          sum_nxt = (neg_r && k_r[0]) ? sum_r - term : sum_r + term;
          if (k_r == n_r) begin
            state_nxt = ST_FIN;
          end else begin
            k_nxt     = k_r + 1'b1;
            prod_nxt  = '0;
            facp_nxt  = '0;
            mcnt_nxt  = tes_pkg::MCNT_W'(tes_pkg::MAG_W - 1);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_sum_nxt   = sum_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      k_r         <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mcnt_r      <= mcnt_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    pw_r      <= pw_nxt;
    fac_r     <= fac_nxt;
    prod_r    <= prod_nxt;
    facp_r    <= facp_nxt;
    sum_r     <= sum_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_series_sum = out_sum_r;

endmodule

`default_nettype wire

// File: hw/rtl/tes_props.sv
// ---------------------------------------------------------------------------
// tes_props
// Port-level assertions for the series block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "truncated_exp_series_assert.svh"

module tes_props (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic        [tes_pkg::COUNT_W-1:0]  in_term_count,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [tes_pkg::SUM_W-1:0]    out_series_sum
);

  // A held result keeps its value
  `TES_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_series_sum), "result changed while stalled")

  // No result straight out of reset
  `TES_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // A taken request keeps the input stalled on the next cycle
  `TES_ASSERT(a_busy_after_req, in_valid && !in_stall |=> in_stall, "input not stalled after request")

  // A zero count with a free output gives a zero result by way of the finish state
  `TES_ASSERT(a_zero_count, in_valid && !in_stall && !out_valid && (in_term_count == '0) |-> ##2 (out_valid && (out_series_sum == '0)), "zero count gave no zero result")

endmodule

bind truncated_exp_series tes_props u_props (.*);

`default_nettype wire
